// ----- design/dhcp_replay_rate_detector_assert.svh -----
// ----------------------------------------------------------------------------
// DHCP replay rate detector assertion macros
// Shared property forms for the detector checks.
// ----------------------------------------------------------------------------
`ifndef DHCP_REPLAY_RATE_DETECTOR_ASSERT_SVH
`define DHCP_REPLAY_RATE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define DRRD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drrd check failed");

// next-cycle implication
`define DRRD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drrd check failed");

`endif

// ----- design/drrd_pkg.sv -----
// ----------------------------------------------------------------------------
// DHCP replay rate detector package
// Entry type, outcome codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package drrd_pkg;

  typedef struct packed {
    logic        valid;
    logic [31:0] xid;
    logic [47:0] mac;
    logic [31:0] last;
    logic [7:0]  cnt;
  } entry_t;

  localparam logic [1:0] OUT_UPDATED  = 2'd0;
  localparam logic [1:0] OUT_INSERTED = 2'd1;
  localparam logic [1:0] OUT_DROPPED  = 2'd2;

  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_EXPIRY    = 2'd2;

  localparam logic [15:0] WINDOW_RESET    = 16'd1;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
  localparam logic [15:0] EXPIRY_RESET    = 16'd300;

endpackage

// ----- design/dhcp_replay_rate_detector.sv -----
// ----------------------------------------------------------------------------
// DHCP replay rate detector
// Tracks (transaction id, MAC) sightings and flags rapid repeats.
// ----------------------------------------------------------------------------
// Input channel: one transfer per DHCP message (transaction id, MAC, time).
// Output channel: one transfer per message (replay alarm, outcome).
// The table is a ring of TABLE_ENTRIES cells rotating past one head port.
// A message takes two full rotations: a lookup scan, then an update and
// expiry sweep, with a calculation step between them and a finish step
// after them that loads the output register. One message is processed at
// a time, so a new input is not taken until the previous result has been
// loaded into the output register.
// in_stall_o is high while a message is in work. The result sits in an
// output register; if the receiver stalls, the next message's result waits
// until the held one is transferred.
// Reset empties the table and loads the register defaults (window 1,
// threshold 3, expiry 300). Registers sit on an APB port at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
module dhcp_replay_rate_detector import drrd_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] transaction_id_i,
  input  logic [47:0] client_mac_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        replay_alarm_o,
  output logic [1:0]  outcome_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [15:0] window_q;
  logic [7:0]  thresh_q;
  logic [15:0] expiry_q;

  logic [2:0]    state_q;
  logic [IW-1:0] idx_q;
  logic [31:0]   xid_q;
  logic [47:0]   mac_q;
  logic [31:0]   now_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [7:0]    hit_cnt_q;
  logic [31:0]   hit_last_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  logic [7:0]    new_cnt_q;
  logic          alarm_q;
  logic          out_valid_q;
  logic          out_alarm_q;
  logic [1:0]    out_outcome_q;

  entry_t ring [TABLE_ENTRIES];
  entry_t head;
  entry_t head_mod;
  logic   shift;
  logic   cfg_wr;
  logic   fin_fire;
  logic [31:0] gap;
  logic [7:0]  inc_cnt;
  logic [1:0]  outcome;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      thresh_q <= THRESHOLD_RESET;
      expiry_q <= EXPIRY_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WINDOW:    window_q <= pwdata[15:0];
        REG_THRESHOLD: thresh_q <= pwdata[7:0];
        REG_EXPIRY:    expiry_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW:    prdata = {16'd0, window_q};
      REG_THRESHOLD: prdata = {24'd0, thresh_q};
      REG_EXPIRY:    prdata = {16'd0, expiry_q};
      default:       prdata = 32'd0;
    endcase
  end

  // cell ring
  assign shift = (state_q == S_SCAN) || (state_q == S_SWEEP);
  assign head  = ring[0];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t cell_in;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign cell_in = head_mod;
    end else begin : g_mid
      assign cell_in = ring[i+1];
    end
    drrd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (ring[i])
    );
  end

  always_comb begin
    head_mod = head;
    if (state_q == S_SWEEP) begin
      if (hit_q && idx_q == hit_idx_q) begin
        head_mod.last = now_q;
        head_mod.cnt  = new_cnt_q;
      end else if (!hit_q && free_q && idx_q == free_idx_q) begin
        head_mod = '{valid: 1'b1, xid: xid_q, mac: mac_q, last: now_q, cnt: 8'd1};
      end
      if (head_mod.valid && ((now_q - head_mod.last) > {16'd0, expiry_q})) begin
        head_mod.valid = 1'b0;
      end
    end
  end

  assign gap      = now_q - hit_last_q;
  assign inc_cnt  = (hit_cnt_q == 8'hFF) ? 8'hFF : hit_cnt_q + 8'd1;
  assign outcome  = hit_q ? OUT_UPDATED : (free_q ? OUT_INSERTED : OUT_DROPPED);
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      xid_q <= transaction_id_i;
      mac_q <= client_mac_i;
      now_q <= now_seconds_i;
    end
    if (state_q == S_SCAN && head.valid && !hit_q &&
        head.xid == xid_q && head.mac == mac_q) begin
      hit_idx_q  <= idx_q;
      hit_cnt_q  <= head.cnt;
      hit_last_q <= head.last;
    end
    if (state_q == S_SCAN && !head.valid && !free_q) begin
      free_idx_q <= idx_q;
    end
    if (state_q == S_CALC) begin
      if (gap <= {16'd0, window_q}) begin
        new_cnt_q <= (inc_cnt >= thresh_q) ? 8'd0 : inc_cnt;
      end else begin
        new_cnt_q <= 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      alarm_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      out_alarm_q   <= 1'b0;
      out_outcome_q <= OUT_UPDATED;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (head.valid && head.xid == xid_q && head.mac == mac_q) begin
            hit_q <= 1'b1;
          end
          if (!head.valid) begin
            free_q <= 1'b1;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= S_CALC;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CALC: begin
          alarm_q <= hit_q && (gap <= {16'd0, window_q}) && (inc_cnt >= thresh_q);
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (idx_q == LAST_IDX) begin
            state_q <= S_FIN;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            out_alarm_q   <= alarm_q;
            out_outcome_q <= outcome;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign replay_alarm_o = out_alarm_q;
  assign outcome_o      = out_outcome_q;

`include "dhcp_replay_rate_detector_assert.svh"

  `DRRD_ASSERT_NOW(a_alarm_on_update, out_valid_o && replay_alarm_o, outcome_o == OUT_UPDATED)
  `DRRD_ASSERT_NOW(a_outcome_code, out_valid_o, outcome_o != 2'd3)
  `DRRD_ASSERT_NEXT(a_scan_to_calc, state_q == S_SCAN && idx_q == LAST_IDX, state_q == S_CALC)
  `DRRD_ASSERT_NOW(a_idle_index, state_q == S_IDLE || state_q == S_CALC, idx_q == '0)

endmodule

// ----- design/drrd_cell.sv -----
// ----------------------------------------------------------------------------
// DHCP replay rate detector table cell
// One table entry; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module drrd_cell import drrd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  logic        valid_q;
  logic [31:0] xid_q;
  logic [47:0] mac_q;
  logic [31:0] last_q;
  logic [7:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      xid_q  <= entry_i.xid;
      mac_q  <= entry_i.mac;
      last_q <= entry_i.last;
      cnt_q  <= entry_i.cnt;
    end
  end

  assign entry_o = '{valid: valid_q, xid: xid_q, mac: mac_q, last: last_q, cnt: cnt_q};

endmodule
